@@ design/hierarchical_tag_set_matcher_macros.svh @@
// Assertion macros for the tag set matcher.
`ifndef HIERARCHICAL_TAG_SET_MATCHER_MACROS_SVH
`define HIERARCHICAL_TAG_SET_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define HTSM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define HTSM_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HTSM_ASSERT(label, clk, rst_n, prop)
`define HTSM_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ design/htsm_pkg.sv @@
// Types and constants of the tag set matcher.
package htsm_pkg;
  localparam int unsigned MaxTags = 1024;
  localparam int unsigned HotBits = 64;
  localparam int unsigned TagW = 10;
  localparam int unsigned EndW = 11;
  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_LOAD = 3'd0, KIND_ADD = 3'd1, KIND_REMOVE = 3'd2, KIND_CLEAR = 3'd3,
    KIND_HAS = 3'd4, KIND_COUNT = 3'd5, KIND_MATCH = 3'd6, KIND_NONE = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    CFG_SIZE = 3'd0, CFG_ALL = 3'd1, CFG_ANY = 3'd2, CFG_NONE = 3'd3, CFG_NEEDS = 3'd4
  } cfg_idx_e;

  typedef enum logic [9:0] {
    ST_INIT  = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_READ  = 10'b0000000100,
    ST_EXEC  = 10'b0000001000,
    ST_SCANR = 10'b0000010000,
    ST_SCAN  = 10'b0000100000,
    ST_REBR  = 10'b0001000000,
    ST_REB   = 10'b0010000000,
    ST_CLR   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  tag;
    logic [15:0] amount;
    logic [63:0] info_ancestor_mask;
    logic [10:0] info_subtree_end;
    logic [6:0]  info_hot_slot;
  } in_beat_t;

  typedef struct packed {
    logic        changed;
    logic        present;
    logic [15:0] tag_amount;
    logic [31:0] version;
  } out_beat_t;
endpackage

@@ design/hierarchical_tag_set_matcher.sv @@
// Top level of the tag set matcher: count store, registry memories, sequencer.
//  channel | signals                          | direction
//  in      | in_valid_i, in_ready_o, in_i      | input beats
//  out     | out_valid_o, out_ready_i, out_o   | result beats
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i   | register writes
// After reset a clearing pass zeroes all 1024 entries of the count store; no beat
// is taken meanwhile. Clear of a non-empty set sweeps all 1024 entries likewise.
// Most beats: read state (memory read), execute state, out state (result register);
// the next input beat is taken in the cycle after the result leaves.
// Remove that erases rebuilds the hot mask over all 1024 tags before the result.
// Cold has scans the subtree, one tag per cycle after a setup state (SCANR).
`include "hierarchical_tag_set_matcher_macros.svh"
module hierarchical_tag_set_matcher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  htsm_pkg::in_beat_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output htsm_pkg::out_beat_t out_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i
);
  logic [15:0] cnt_mem [htsm_pkg::MaxTags];
  logic [63:0] anc_mem [htsm_pkg::MaxTags];
  logic [10:0] end_mem [htsm_pkg::MaxTags];
  logic [6:0]  slot_mem [htsm_pkg::MaxTags];

  htsm_pkg::state_e state_q, state_d;
  htsm_pkg::in_beat_t beat_q;
  logic [10:0] size_q;
  logic [63:0] all_q, any_q, none_q;
  logic        needs_q;
  logic [63:0] hot_q, hot_d;
  logic [31:0] ver_q, ver_d;
  logic [10:0] total_q, total_d;
  logic [10:0] idx_q, idx_d;
  logic [10:0] lim_q, lim_d;
  logic [15:0] cnt_rd_q;
  logic [63:0] anc_rd_q;
  logic [10:0] end_rd_q;
  logic [6:0]  slot_rd_q;
  logic        out_valid_q, out_valid_d;
  htsm_pkg::out_beat_t out_q, out_d;

  logic        in_fire;
  logic        cnt_we;
  logic [9:0]  cnt_wa, rd_a;
  logic [15:0] cnt_wd;
  logic        load_we;
  logic [16:0] sum;
  logic [10:0] vsize;
  logic        in_size;

  assign in_ready_o  = (state_q == htsm_pkg::ST_IDLE) && !out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign vsize   = (size_q > 11'(htsm_pkg::MaxTags)) ? 11'(htsm_pkg::MaxTags) : size_q;
  assign in_size = {1'b0, beat_q.tag} < vsize;
  assign sum     = {1'b0, cnt_rd_q} + {1'b0, beat_q.amount};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      all_q <= '0;
      any_q <= '0;
      none_q <= '0;
      needs_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        htsm_pkg::CFG_SIZE:  size_q <= cfg_data_i[10:0];
        htsm_pkg::CFG_ALL:   all_q <= cfg_data_i;
        htsm_pkg::CFG_ANY:   any_q <= cfg_data_i;
        htsm_pkg::CFG_NONE:  none_q <= cfg_data_i;
        htsm_pkg::CFG_NEEDS: needs_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_q <= cnt_mem[rd_a];
    if (load_we) begin
      anc_mem[beat_q.tag]  <= beat_q.info_ancestor_mask;
      end_mem[beat_q.tag]  <= beat_q.info_subtree_end;
      slot_mem[beat_q.tag] <= beat_q.info_hot_slot;
    end
    anc_rd_q  <= anc_mem[rd_a];
    end_rd_q  <= end_mem[rd_a];
    slot_rd_q <= slot_mem[rd_a];
    if (in_fire) beat_q <= in_i;
  end

  always_comb begin
    state_d = state_q;
    hot_d = hot_q;
    ver_d = ver_q;
    total_d = total_q;
    idx_d = idx_q;
    lim_d = lim_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    cnt_we = 1'b0;
    cnt_wa = beat_q.tag;
    cnt_wd = '0;
    load_we = 1'b0;
    rd_a = beat_q.tag;
    case (state_q)
      htsm_pkg::ST_INIT: begin
        cnt_we = 1'b1;
        cnt_wa = idx_q[9:0];
        idx_d = idx_q + 11'd1;
        if (idx_q == 11'(htsm_pkg::MaxTags - 1)) state_d = htsm_pkg::ST_IDLE;
      end
      htsm_pkg::ST_IDLE: begin
        if (in_fire) state_d = htsm_pkg::ST_READ;
      end
      htsm_pkg::ST_READ: state_d = htsm_pkg::ST_EXEC;
      htsm_pkg::ST_EXEC: begin
        out_d = '0;
        state_d = htsm_pkg::ST_OUT;
        case (beat_q.kind)
          htsm_pkg::KIND_LOAD: load_we = 1'b1;
          htsm_pkg::KIND_ADD: begin
            if (beat_q.amount != '0 && in_size) begin
              cnt_we = 1'b1;
              if (cnt_rd_q != '0) begin
                cnt_wd = sum[16] ? htsm_pkg::CountMax : sum[15:0];
              end else begin
                cnt_wd = beat_q.amount;
                hot_d = hot_q | anc_rd_q;
                total_d = total_q + 11'd1;
                ver_d = ver_q + 32'd1;
                out_d.changed = 1'b1;
              end
            end
          end
          htsm_pkg::KIND_REMOVE: begin
            if (beat_q.amount != '0 && cnt_rd_q != '0) begin
              cnt_we = 1'b1;
              if (cnt_rd_q > beat_q.amount) begin
                cnt_wd = cnt_rd_q - beat_q.amount;
              end else begin
                total_d = total_q - 11'd1;
                ver_d = ver_q + 32'd1;
                out_d.changed = 1'b1;
                hot_d = '0;
                idx_d = '0;
                state_d = htsm_pkg::ST_REBR;
              end
            end
          end
          htsm_pkg::KIND_CLEAR: begin
            if (total_q != '0) begin
              hot_d = '0;
              total_d = '0;
              ver_d = ver_q + 32'd1;
              idx_d = '0;
              state_d = htsm_pkg::ST_CLR;
            end
          end
          htsm_pkg::KIND_HAS: begin
            if (in_size) begin
              if (slot_rd_q < 7'(htsm_pkg::HotBits)) begin
                out_d.present = hot_q[slot_rd_q[5:0]];
              end else begin
                idx_d = {1'b0, beat_q.tag};
                lim_d = (end_rd_q > 11'(htsm_pkg::MaxTags)) ?
                        11'(htsm_pkg::MaxTags) : end_rd_q;
                state_d = htsm_pkg::ST_SCANR;
              end
            end
          end
          htsm_pkg::KIND_COUNT: out_d.tag_amount = cnt_rd_q;
          htsm_pkg::KIND_MATCH: begin
            out_d.present = ((all_q & ~hot_q) == '0) && ((none_q & hot_q) == '0) &&
                            (!needs_q || ((any_q & hot_q) != '0));
          end
          default: ;
        endcase
      end
      htsm_pkg::ST_SCANR: begin
        rd_a = idx_q[9:0];
        if (idx_q >= lim_q) state_d = htsm_pkg::ST_OUT;
        else state_d = htsm_pkg::ST_SCAN;
      end
      htsm_pkg::ST_SCAN: begin
        rd_a = idx_q[9:0] + 10'd1;
        if (cnt_rd_q != '0) begin
          out_d.present = 1'b1;
          state_d = htsm_pkg::ST_OUT;
        end else begin
          idx_d = idx_q + 11'd1;
          if (idx_q + 11'd1 >= lim_q) state_d = htsm_pkg::ST_OUT;
        end
      end
      htsm_pkg::ST_REBR: begin
        rd_a = idx_q[9:0];
        if (idx_q[9:0] == beat_q.tag) begin
          cnt_we = 1'b1;
          cnt_wa = beat_q.tag;
          cnt_wd = '0;
        end
        state_d = htsm_pkg::ST_REB;
      end
      htsm_pkg::ST_REB: begin
        rd_a = idx_q[9:0] + 10'd1;
        if (cnt_rd_q != '0 && idx_q[9:0] != beat_q.tag) hot_d = hot_q | anc_rd_q;
        idx_d = idx_q + 11'd1;
        if (idx_q == 11'(htsm_pkg::MaxTags - 1)) state_d = htsm_pkg::ST_OUT;
      end
      htsm_pkg::ST_CLR: begin
        cnt_we = 1'b1;
        cnt_wa = idx_q[9:0];
        idx_d = idx_q + 11'd1;
        if (idx_q == 11'(htsm_pkg::MaxTags - 1)) state_d = htsm_pkg::ST_OUT;
      end
      htsm_pkg::ST_OUT: begin
        out_d.version = ver_q;
        out_valid_d = 1'b1;
        state_d = htsm_pkg::ST_IDLE;
      end
      default: state_d = htsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htsm_pkg::ST_INIT;
      hot_q <= '0;
      ver_q <= '0;
      total_q <= '0;
      idx_q <= '0;
      lim_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hot_q <= hot_d;
      ver_q <= ver_d;
      total_q <= total_d;
      idx_q <= idx_d;
      lim_q <= lim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  `HTSM_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q))
  `HTSM_ASSERT(a_no_take_busy, clk_i, rst_ni, in_fire |=> (state_q == htsm_pkg::ST_READ))
  `HTSM_ASSERT(a_out_from_out, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == htsm_pkg::ST_OUT))
  `HTSM_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> !out_valid_o)
endmodule
